@@ hw/rtl/dag_level_topological_sort_macros.svh @@
// Assertion macros shared by the level sort RTL.
`ifndef DAG_LEVEL_TOPOLOGICAL_SORT_MACROS_SVH
`define DAG_LEVEL_TOPOLOGICAL_SORT_MACROS_SVH
`ifndef SYNTHESIS
`define DLTS_ASSERT_ALWAYS(name, expr) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("dlts assertion failed");
`define DLTS_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dlts assertion failed");
`else
`define DLTS_ASSERT_ALWAYS(name, expr)
`define DLTS_ASSERT_NEXT(name, ante, cons)
`endif
`endif

@@ hw/rtl/dlts_pkg.sv @@
// Types and constants shared by the level sort modules.
package dlts_pkg;

   localparam int MAX_NODES = 32;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int CNT_W     = $clog2(MAX_NODES + 1);
   localparam int LEVEL_W   = 5;
   localparam int ROUND_W   = 6;
   localparam int MASK_W    = 32;
   localparam logic [CNT_W-1:0] NODE_COUNT_RESET = CNT_W'(MAX_NODES);

   typedef struct packed {
      logic [NODE_W-1:0] row_index;
      logic [MASK_W-1:0] successor_mask;
      logic              last_row;
   } dlts_req_type;

   typedef struct packed {
      logic [NODE_W-1:0]  node_index;
      logic [LEVEL_W-1:0] node_level;
      logic               cycle_found;
      logic               last_result;
   } dlts_rsp_type;

   typedef struct packed {
      logic load;
      logic start;
      logic scan;
      logic place;
      logic emit;
      logic clear;
   } dlts_cmd_type;

   typedef struct packed {
      logic k_last;
      logic none_ready;
   } dlts_status_type;

endpackage

@@ hw/rtl/dag_level_topological_sort.sv @@
// Top level of the levelized topological sort: controller plus datapath.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_ready   req_data (row, successor mask, last row)
//   rsp      out        rsp_valid/rsp_ready   rsp_data (node, level, cycle, last)
//   csr      in         csr_wr_en             csr_wr_data (node count)
//
// Rows load at one transaction per cycle.
// After the last row, each round scans the n active rows one per cycle and then
// places the ready nodes in the place state.
// The n results then leave at one per cycle while rsp_ready is high.
// req_ready is low from the last row until the final result has been loaded.
// Reset is synchronous and clears the graph at once; there is no clearing pass.
module dag_level_topological_sort
   import dlts_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data,
   input  logic             req_valid,
   output logic             req_ready,
   input  dlts_req_type     req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dlts_rsp_type     rsp_data
);

   dlts_cmd_type    cmd;
   dlts_status_type status;

   dlts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_row),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dlts_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_data    (rsp_data)
   );

endmodule

@@ hw/rtl/dlts_ctrl.sv @@
// Controller state machine that sequences loading, level rounds and result output.
`include "dag_level_topological_sort_macros.svh"
module dlts_ctrl
   import dlts_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_last,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  dlts_status_type status,
   output dlts_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_LOAD  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_PLACE = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_take;

   assign req_ready = (state_ff == ST_LOAD);
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  cmd.start = 1'b1;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.k_last) begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            cmd.place = 1'b1;
            state_in  = status.none_ready ? ST_EMIT : ST_SCAN;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               if (status.k_last) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `DLTS_ASSERT_NEXT(a_scan_ends_in_place, (state_ff == ST_SCAN) && status.k_last, state_ff == ST_PLACE)
   `DLTS_ASSERT_ALWAYS(a_rsp_rises_from_emit, !$rose(rsp_valid_ff) || $past(state_ff == ST_EMIT))
   `DLTS_ASSERT_NEXT(a_place_empty_goes_emit, (state_ff == ST_PLACE) && status.none_ready, state_ff == ST_EMIT)

endmodule

@@ hw/rtl/dlts_dpath.sv @@
// Datapath with adjacency rows, placed mask, round counter, levels and result register.
`include "dag_level_topological_sort_macros.svh"
module dlts_dpath
   import dlts_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data,
   input  dlts_req_type     req_data,
   input  dlts_cmd_type     cmd,
   output dlts_status_type  status,
   output dlts_rsp_type     rsp_data
);

   logic [MASK_W-1:0]  rows_ff [MAX_NODES];
   logic [LEVEL_W-1:0] levels_ff [MAX_NODES];
   logic [CNT_W-1:0]   node_count_ff;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [NODE_W-1:0]  k_ff;
   logic [MASK_W-1:0]  reached_ff;
   logic [MASK_W-1:0]  placed_ff;
   logic [ROUND_W-1:0] round_ff;
   dlts_rsp_type       rsp_ff, rsp_in;
   logic [MASK_W-1:0]  all_mask;
   logic [MASK_W-1:0]  unplaced;
   logic [MASK_W-1:0]  ready_mask;

   always_comb begin
      if (node_count_ff == '0) begin
         n_in = CNT_W'(1);
      end else if (node_count_ff > CNT_W'(MAX_NODES)) begin
         n_in = CNT_W'(MAX_NODES);
      end else begin
         n_in = node_count_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < MASK_W; i++) begin
         all_mask[i] = (CNT_W'(i) < n_ff);
      end
   end

   assign unplaced          = all_mask & ~placed_ff;
   assign ready_mask        = unplaced & ~reached_ff;
   assign status.k_last     = ({1'b0, k_ff} == (n_ff - CNT_W'(1)));
   assign status.none_ready = (ready_mask == '0);

   always_comb begin
      rsp_in.node_index  = k_ff;
      rsp_in.node_level  = placed_ff[k_ff] ? levels_ff[k_ff] : '0;
      rsp_in.cycle_found = !placed_ff[k_ff];
      rsp_in.last_result = status.k_last;
   end

   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
         n_ff          <= NODE_COUNT_RESET;
         k_ff          <= '0;
         reached_ff    <= '0;
         placed_ff     <= '0;
         round_ff      <= '0;
         for (int i = 0; i < MAX_NODES; i++) begin
            rows_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            node_count_ff <= csr_wr_data;
         end
         if (cmd.load) begin
            rows_ff[req_data.row_index] <= req_data.successor_mask;
         end
         if (cmd.start) begin
            n_ff       <= n_in;
            k_ff       <= '0;
            reached_ff <= '0;
         end
         if (cmd.scan) begin
            if (unplaced[k_ff]) begin
               reached_ff <= reached_ff | rows_ff[k_ff];
            end
            k_ff <= k_ff + NODE_W'(1);
         end
         if (cmd.place) begin
            k_ff       <= '0;
            reached_ff <= '0;
            if (ready_mask != '0) begin
               placed_ff <= placed_ff | ready_mask;
               round_ff  <= round_ff + ROUND_W'(1);
            end
         end
         if (cmd.emit) begin
            k_ff <= cmd.clear ? '0 : k_ff + NODE_W'(1);
         end
         if (cmd.clear) begin
            placed_ff <= '0;
            round_ff  <= '0;
            for (int i = 0; i < MAX_NODES; i++) begin
               rows_ff[i] <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.place) begin
         for (int i = 0; i < MAX_NODES; i++) begin
            if (ready_mask[i]) begin
               levels_ff[i] <= round_ff[LEVEL_W-1:0];
            end
         end
      end
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   `DLTS_ASSERT_NEXT(a_clear_resets_run, cmd.clear, (placed_ff == '0) && (round_ff == '0))
   `DLTS_ASSERT_ALWAYS(a_placed_within_count, (placed_ff & ~all_mask) == '0)
   `DLTS_ASSERT_NEXT(a_round_advances, cmd.place && (ready_mask != '0), round_ff == $past(round_ff) + ROUND_W'(1))

endmodule
